FILE: rtl/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, clocked on clk and held off during reset
`define ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on clk and held off during reset
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/pcrt_pkg.sv
// shared types and constants of the point cloud rigid transform
`timescale 1ns / 1ps

package pcrt_pkg;

    localparam int QUAT_W      = 32;
    localparam int INTENSITY_W = 32;
    localparam int REG_INDEX_W = 3;
    localparam int ROUND_SHIFT = 30;
    localparam int PIPE_DEPTH  = 10;

    localparam logic [QUAT_W-1:0] QUAT_ONE   = 32'h4000_0000;
    localparam logic [63:0]       ROUND_HALF = 64'd1 << (ROUND_SHIFT - 1);

    typedef enum logic [REG_INDEX_W-1:0] {
        REG_QUAT_W  = 3'd0,
        REG_QUAT_X  = 3'd1,
        REG_QUAT_Y  = 3'd2,
        REG_QUAT_Z  = 3'd3,
        REG_SHIFT_X = 3'd4,
        REG_SHIFT_Y = 3'd5,
        REG_SHIFT_Z = 3'd6
    } reg_index_t;

    // stage enables of one multiply-and-round unit
    typedef struct packed {
        logic prod;
        logic sum;
        logic rnd;
    } mul_en_t;

endpackage

FILE: rtl/pcrt_if.sv
// valid/ready channels for input points and transformed points
`timescale 1ns / 1ps

interface pcrt_point_if #(
    parameter int COORD_WIDTH = 32
);
    logic                                   valid;
    logic                                   ready;
    logic signed [COORD_WIDTH-1:0]          point_x;
    logic signed [COORD_WIDTH-1:0]          point_y;
    logic signed [COORD_WIDTH-1:0]          point_z;
    logic [pcrt_pkg::INTENSITY_W-1:0]       point_intensity;
    logic                                   point_last;

    modport source (
        output valid, point_x, point_y, point_z, point_intensity, point_last,
        input  ready
    );
    modport sink (
        input  valid, point_x, point_y, point_z, point_intensity, point_last,
        output ready
    );
endinterface

interface pcrt_moved_if #(
    parameter int COORD_WIDTH = 32
);
    logic                                   valid;
    logic                                   ready;
    logic signed [COORD_WIDTH-1:0]          moved_x;
    logic signed [COORD_WIDTH-1:0]          moved_y;
    logic signed [COORD_WIDTH-1:0]          moved_z;
    logic [pcrt_pkg::INTENSITY_W-1:0]       moved_intensity;
    logic                                   moved_last;

    modport source (
        output valid, moved_x, moved_y, moved_z, moved_intensity, moved_last,
        input  ready
    );
    modport sink (
        input  valid, moved_x, moved_y, moved_z, moved_intensity, moved_last,
        output ready
    );
endinterface

FILE: rtl/pcrt_mulrnd.sv
// three-stage Q2.30 by fixed-point multiply with round half away from zero
`timescale 1ns / 1ps

module pcrt_mulrnd #(
    parameter int BW = 32
) (
    input  logic                                clk,
    input  pcrt_pkg::mul_en_t                   en,
    input  logic signed [pcrt_pkg::QUAT_W-1:0]  a,
    input  logic signed [BW-1:0]                b,
    output logic signed [BW+1:0]                r
);

    localparam int QW   = pcrt_pkg::QUAT_W;
    localparam int LO_W = BW / 2;
    localparam int HI_W = BW - LO_W;
    localparam int PW   = QW + BW;
    localparam int RS   = pcrt_pkg::ROUND_SHIFT;

    logic signed [QW+HI_W-1:0] ph_reg;
    logic signed [QW+LO_W:0]   pl_reg;
    logic signed [PW-1:0]      p_reg;
    logic signed [PW-1:0]      p_bias;
    logic signed [BW+1:0]      r_reg;

    // negative products get one less bias so the floor shift rounds away from zero
    assign p_bias = p_reg + PW'(pcrt_pkg::ROUND_HALF) - PW'(p_reg[PW-1]);

    always_ff @(posedge clk)
    begin
        if (en.prod)
        begin
            ph_reg <= a * $signed(b[BW-1:LO_W]);
            pl_reg <= a * $signed({1'b0, b[LO_W-1:0]});
        end
        if (en.sum)
        begin
            p_reg <= (PW'(ph_reg) <<< LO_W) + PW'(pl_reg);
        end
        if (en.rnd)
        begin
            r_reg <= p_bias[PW-1:RS];
        end
    end

    assign r = r_reg;

endmodule

FILE: rtl/point_cloud_rigid_transform.sv
// point cloud rigid transform: quaternion rotation, translation, saturation
//
//   channel   dir   handshake        beat contents
//   points    in    valid / ready    point_x/y/z Q16.16, point_intensity, point_last
//   moved     out   valid / ready    moved_x/y/z Q16.16 saturated, intensity, last
//   cfg       in    cfg_we           cfg_index, cfg_data (quaternion Q2.30, shift Q16.16)
//
// one point per cycle sustained while the output is not stalled, ten register stages
// the stages are two chained multiply-and-round units of three stages each,
// plus input, cross-difference, partial-sum and saturate/output stages
// each stage holds while the next is full and stalled, so bubbles close up under stall
// reset clears all valid bits and loads the identity rotation with zero shift
`timescale 1ns / 1ps

module point_cloud_rigid_transform #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    cfg_we,
    input  logic [pcrt_pkg::REG_INDEX_W-1:0]        cfg_index,
    input  logic [((COORD_WIDTH > pcrt_pkg::QUAT_W) ? COORD_WIDTH
                                                    : pcrt_pkg::QUAT_W)-1:0] cfg_data,
    pcrt_point_if.sink                              points,
    pcrt_moved_if.source                            moved
);

    localparam int CW    = COORD_WIDTH;
    localparam int QW    = pcrt_pkg::QUAT_W;
    localparam int IW    = pcrt_pkg::INTENSITY_W;
    localparam int DEPTH = pcrt_pkg::PIPE_DEPTH;
    localparam int R1W   = CW + 2;
    localparam int TW    = CW + 4;
    localparam int R2W   = TW + 2;
    localparam int UTW   = R2W + 1;
    localparam int SW    = CW + 9;

    localparam logic [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
        logic [IW-1:0]        intensity;
        logic                 last;
    } side_t;

    // configuration
    logic signed [QW-1:0] qw_reg, qx_reg, qy_reg, qz_reg;
    logic signed [CW-1:0] shift_reg [3];

    // pipeline control and side data
    logic [DEPTH:1]       vld_reg;
    logic [DEPTH:1]       en;
    side_t                side_reg [1:DEPTH-1];

    // first rotation step: u x v
    logic signed [QW-1:0]  mul1_a [6];
    logic signed [CW-1:0]  mul1_b [6];
    logic signed [R1W-1:0] r1 [6];
    logic signed [TW-1:0]  t_reg [3];
    logic signed [R1W:0]   c_diff [3];
    pcrt_pkg::mul_en_t     mul1_en;

    // second step: w*t and u x t
    logic signed [QW-1:0]  mul2_a [9];
    logic signed [TW-1:0]  mul2_b [9];
    logic signed [R2W-1:0] r2 [9];
    pcrt_pkg::mul_en_t     mul2_en;

    logic signed [SW-1:0]  part_reg [3];
    logic signed [UTW-1:0] ut_reg [3];
    logic signed [SW-1:0]  total [3];
    logic signed [CW-1:0]  out_reg [3];
    logic [IW-1:0]         out_int_reg;
    logic                  out_last_reg;

    function automatic logic [CW-1:0] sat(input logic [SW-1:0] s);
        logic [SW-CW:0] top;
        top = s[SW-1:CW-1];
        if ((top == '0) || (top == '1))
        begin
            return s[CW-1:0];
        end
        else if (s[SW-1])
        begin
            return CMIN;
        end
        return CMAX;
    endfunction

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qw_reg       <= pcrt_pkg::QUAT_ONE;
            qx_reg       <= '0;
            qy_reg       <= '0;
            qz_reg       <= '0;
            shift_reg[0] <= '0;
            shift_reg[1] <= '0;
            shift_reg[2] <= '0;
        end
        else if (cfg_we)
        begin
            case (pcrt_pkg::reg_index_t'(cfg_index))
                pcrt_pkg::REG_QUAT_W:  qw_reg       <= cfg_data[QW-1:0];
                pcrt_pkg::REG_QUAT_X:  qx_reg       <= cfg_data[QW-1:0];
                pcrt_pkg::REG_QUAT_Y:  qy_reg       <= cfg_data[QW-1:0];
                pcrt_pkg::REG_QUAT_Z:  qz_reg       <= cfg_data[QW-1:0];
                pcrt_pkg::REG_SHIFT_X: shift_reg[0] <= cfg_data[CW-1:0];
                pcrt_pkg::REG_SHIFT_Y: shift_reg[1] <= cfg_data[CW-1:0];
                pcrt_pkg::REG_SHIFT_Z: shift_reg[2] <= cfg_data[CW-1:0];
                default: ;
            endcase
        end
    end

    // a stage loads when it is empty or its successor moves on
    always_comb
    begin
        en[DEPTH] = !vld_reg[DEPTH] || moved.ready;
        for (int k = DEPTH - 1; k >= 1; k--)
        begin
            en[k] = !vld_reg[k] || en[k+1];
        end
    end

    assign points.ready = en[1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (en[1])
            begin
                vld_reg[1] <= points.valid;
            end
            for (int k = 2; k <= DEPTH; k++)
            begin
                if (en[k])
                begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            side_reg[1] <= '{x: points.point_x, y: points.point_y, z: points.point_z,
                             intensity: points.point_intensity, last: points.point_last};
        end
        for (int k = 2; k <= DEPTH - 1; k++)
        begin
            if (en[k])
            begin
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    // u x v products: uy*vz, uz*vy, uz*vx, ux*vz, ux*vy, uy*vx
    always_comb
    begin
        mul1_a = '{qy_reg, qz_reg, qz_reg, qx_reg, qx_reg, qy_reg};
        mul1_b = '{side_reg[1].z, side_reg[1].y, side_reg[1].x,
                   side_reg[1].z, side_reg[1].y, side_reg[1].x};
    end

    assign mul1_en = '{prod: en[2], sum: en[3], rnd: en[4]};

    for (genvar g = 0; g < 6; g++)
    begin : g_mul1
        pcrt_mulrnd #(
            .BW (CW)
        ) u_mul (
            .clk (clk),
            .en  (mul1_en),
            .a   (mul1_a[g]),
            .b   (mul1_b[g]),
            .r   (r1[g])
        );
    end

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            c_diff[k] = (R1W+1)'(r1[2*k]) - (R1W+1)'(r1[2*k+1]);
        end
    end

    // t = 2c
    always_ff @(posedge clk)
    begin
        if (en[5])
        begin
            for (int k = 0; k < 3; k++)
            begin
                t_reg[k] <= {c_diff[k], 1'b0};
            end
        end
    end

    // w*t on 0..2, then u x t pairs: uy*tz, uz*ty, uz*tx, ux*tz, ux*ty, uy*tx
    always_comb
    begin
        mul2_a = '{qw_reg, qw_reg, qw_reg,
                   qy_reg, qz_reg, qz_reg, qx_reg, qx_reg, qy_reg};
        mul2_b = '{t_reg[0], t_reg[1], t_reg[2],
                   t_reg[2], t_reg[1], t_reg[0], t_reg[2], t_reg[1], t_reg[0]};
    end

    assign mul2_en = '{prod: en[6], sum: en[7], rnd: en[8]};

    for (genvar g = 0; g < 9; g++)
    begin : g_mul2
        pcrt_mulrnd #(
            .BW (TW)
        ) u_mul (
            .clk (clk),
            .en  (mul2_en),
            .a   (mul2_a[g]),
            .b   (mul2_b[g]),
            .r   (r2[g])
        );
    end

    always_ff @(posedge clk)
    begin
        if (en[9])
        begin
            part_reg[0] <= SW'($signed(side_reg[8].x)) + SW'(r2[0]) + SW'(shift_reg[0]);
            part_reg[1] <= SW'($signed(side_reg[8].y)) + SW'(r2[1]) + SW'(shift_reg[1]);
            part_reg[2] <= SW'($signed(side_reg[8].z)) + SW'(r2[2]) + SW'(shift_reg[2]);
            for (int k = 0; k < 3; k++)
            begin
                ut_reg[k] <= UTW'(r2[3+2*k]) - UTW'(r2[4+2*k]);
            end
        end
    end

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            total[k] = part_reg[k] + SW'(ut_reg[k]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[DEPTH])
        begin
            for (int k = 0; k < 3; k++)
            begin
                out_reg[k] <= sat(total[k]);
            end
            out_int_reg  <= side_reg[DEPTH-1].intensity;
            out_last_reg <= side_reg[DEPTH-1].last;
        end
    end

    assign moved.valid           = vld_reg[DEPTH];
    assign moved.moved_x         = out_reg[0];
    assign moved.moved_y         = out_reg[1];
    assign moved.moved_z         = out_reg[2];
    assign moved.moved_intensity = out_int_reg;
    assign moved.moved_last      = out_last_reg;

endmodule

FILE: rtl/pcrt_checker.sv
// port-level checks of the point cloud rigid transform, bound to the top level
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pcrt_checker #(
    parameter int COORD_WIDTH = 32
) (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 in_valid,
    input logic                                 in_ready,
    input logic                                 out_valid,
    input logic                                 out_ready,
    input logic [COORD_WIDTH-1:0]               out_x,
    input logic [COORD_WIDTH-1:0]               out_y,
    input logic [COORD_WIDTH-1:0]               out_z,
    input logic [pcrt_pkg::INTENSITY_W-1:0]     out_intensity,
    input logic                                 out_last
);

    localparam int DEPTH = pcrt_pkg::PIPE_DEPTH;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             in_beat;
    logic             out_beat;
    logic [3*COORD_WIDTH+pcrt_pkg::INTENSITY_W:0] out_payload;

    assign in_beat     = in_valid && in_ready;
    assign out_beat    = out_valid && out_ready;
    assign out_payload = {out_x, out_y, out_z, out_intensity, out_last};
    assign cnt_next    = cnt_reg + CNT_W'(in_beat) - CNT_W'(out_beat);

    // points inside the block
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    `ASSERT_NEXT(a_valid_held, out_valid && !out_ready, out_valid, "result beat dropped while stalled")
    `ASSERT_NEXT(a_payload_held, out_valid && !out_ready, $stable(out_payload), "result changed while stalled")
    `ASSERT_IMPL(a_no_phantom, out_valid, cnt_reg != '0, "result beat with no point inside")
    `ASSERT_IMPL(a_full_stalls, (cnt_reg == CNT_W'(DEPTH)) && !out_ready, !in_ready, "input taken while pipeline full")

endmodule

bind point_cloud_rigid_transform pcrt_checker #(
    .COORD_WIDTH (COORD_WIDTH)
) u_pcrt_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (points.valid),
    .in_ready      (points.ready),
    .out_valid     (moved.valid),
    .out_ready     (moved.ready),
    .out_x         (moved.moved_x),
    .out_y         (moved.moved_y),
    .out_z         (moved.moved_z),
    .out_intensity (moved.moved_intensity),
    .out_last      (moved.moved_last)
);
